### sv/indexed_linked_list_engine_top_assert.svh
// Assertion macros for the list engine back end.
`ifndef INDEXED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define ILE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### sv/ile_pkg.sv
// Shared types and codes for the indexed linked list engine.
package ile_pkg;

  localparam logic [3:0] OP_INSERT     = 4'd0;
  localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd2;
  localparam logic [3:0] OP_GET        = 4'd3;
  localparam logic [3:0] OP_SET        = 4'd4;
  localparam logic [3:0] OP_REMOVE     = 4'd5;
  localparam logic [3:0] OP_POP_FRONT  = 4'd6;
  localparam logic [3:0] OP_POP_BACK   = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int POS_BITS = 7;

  typedef enum logic [2:0] {
    K_NOP,
    K_INS,
    K_GET,
    K_SET,
    K_REM,
    K_CLR
  } kind_t;

  // Which list position the command addresses.
  typedef enum logic [1:0] {
    SEL_POS,
    SEL_FIRST,
    SEL_LAST
  } sel_t;

  typedef struct packed {
    kind_t                kind;
    sel_t                 sel;
    logic [POS_BITS-1:0]  pos;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_APPEND,
    S_WALK,
    S_ACT,
    S_DCAP,
    S_REMWR,
    S_LNK1,
    S_LNK2,
    S_HEAD,
    S_TAIL,
    S_OUT
  } bstate_t;

endpackage

### sv/ile_front.sv
// Front end: accepts requests and classifies them into list commands.
module ile_front import ile_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           op,
  input  logic [POS_BITS-1:0]  position,
  input  logic [31:0]          data_in,
  output logic                 push,
  input  logic                 push_ready,
  output cmd_t                 cmd,
  output logic [WORD_BITS-1:0] word
);

  assign in_ready = push_ready;
  assign push     = in_valid;
  assign word     = WORD_BITS'(data_in);

  always_comb begin
    cmd.pos  = position;
    cmd.sel  = SEL_POS;
    cmd.kind = K_NOP;
    case (op)
      OP_INSERT:     cmd.kind = K_INS;
      OP_PUSH_FRONT: begin
        cmd.kind = K_INS;
        cmd.sel  = SEL_FIRST;
      end
      OP_PUSH_BACK:  begin
        cmd.kind = K_INS;
        cmd.sel  = SEL_LAST;
      end
      OP_GET:        cmd.kind = K_GET;
      OP_SET:        cmd.kind = K_SET;
      OP_REMOVE:     cmd.kind = K_REM;
      OP_POP_FRONT:  begin
        cmd.kind = K_REM;
        cmd.sel  = SEL_FIRST;
      end
      OP_POP_BACK:   begin
        cmd.kind = K_REM;
        cmd.sel  = SEL_LAST;
      end
      OP_CLEAR:      cmd.kind = K_CLR;
      default:       cmd.kind = K_NOP;
    endcase
  end

endmodule

### sv/ile_queue.sv
// Two-entry command queue between front end and list sequencer.
module ile_queue import ile_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 push_ready,
  input  cmd_t                 push_cmd,
  input  logic [WORD_BITS-1:0] push_word,
  output logic                 pop_valid,
  input  logic                 pop,
  output cmd_t                 pop_cmd,
  output logic [WORD_BITS-1:0] pop_word
);

  cmd_t                 cmds  [2];
  logic [WORD_BITS-1:0] words [2];
  logic                 wptr;
  logic                 rptr;
  logic [1:0]           fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = cmds[rptr];
  assign pop_word   = words[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmds[wptr]  <= push_cmd;
      words[wptr] <= push_word;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### sv/ile_back.sv
// Back end: list sequencer with node pool memories, walk, relink and result register.
module ile_back import ile_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int WORD_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  cmd_t                 q_cmd,
  input  logic [WORD_BITS-1:0] q_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [31:0]          data_out,
  output logic [6:0]           item_count,
  output logic [31:0]          head_data,
  output logic [31:0]          tail_data
);

  `include "indexed_linked_list_engine_top_assert.svh"

  localparam int SW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW  = $clog2(POOL_DEPTH + 1);
  localparam int PW  = (CW > POS_BITS) ? CW : POS_BITS;
  localparam int NCH = (POOL_DEPTH + 7) / 8;
  localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int IW  = $clog2(NCH * 8);

  // pool memories
  logic [WORD_BITS-1:0] words_mem [POOL_DEPTH];
  logic [SW-1:0]        nxt_mem   [POOL_DEPTH];
  logic [SW-1:0]        prv_mem   [POOL_DEPTH];
  logic [WORD_BITS-1:0] word_rd;
  logic [SW-1:0]        nxt_rd;
  logic [SW-1:0]        prv_rd;

  logic                 w_we;
  logic [SW-1:0]        w_waddr;
  logic [WORD_BITS-1:0] w_wdata;
  logic [SW-1:0]        w_raddr;
  logic                 n_we;
  logic [SW-1:0]        n_waddr;
  logic [SW-1:0]        n_wdata;
  logic                 p_we;
  logic [SW-1:0]        p_waddr;
  logic [SW-1:0]        p_wdata;
  logic [SW-1:0]        l_raddr;

  bstate_t              state, state_next;
  cmd_t                 cmd, cmd_next;
  logic [WORD_BITS-1:0] word, word_next;
  logic [PW-1:0]        pos_r, pos_r_next;
  logic [SW-1:0]        head, head_next;
  logic [SW-1:0]        tail, tail_next;
  logic [CW-1:0]        count, count_next;
  logic [POOL_DEPTH-1:0] inuse, inuse_next;
  logic [SW-1:0]        nslot, nslot_next;
  logic [SW-1:0]        loc, loc_next;
  logic [SW-1:0]        cur, cur_next;
  logic                 fresh, fresh_next;
  logic [PW-1:0]        rem, rem_next;
  logic                 dir, dir_next;
  logic [CHW-1:0]       chunk, chunk_next;
  logic [1:0]           st, st_next;
  logic [WORD_BITS-1:0] dout, dout_next;
  logic [WORD_BITS-1:0] hword, hword_next;
  logic                 out_valid_next;
  logic                 res_load;
  logic [1:0]           status_next;
  logic [31:0]          data_out_next;
  logic [6:0]           item_count_next;
  logic [31:0]          head_data_next;
  logic [31:0]          tail_data_next;

  always_ff @(posedge clk) begin
    if (w_we) words_mem[w_waddr] <= w_wdata;
    if (n_we) nxt_mem[n_waddr] <= n_wdata;
    if (p_we) prv_mem[p_waddr] <= p_wdata;
    word_rd <= words_mem[w_raddr];
    nxt_rd  <= nxt_mem[l_raddr];
    prv_rd  <= prv_mem[l_raddr];
  end

  always_comb begin
    logic [PW-1:0]  cnt_ext;
    logic [PW-1:0]  cm1;
    logic [PW-1:0]  pe;
    logic [PW-1:0]  wpos;
    logic           wk_dir;
    logic [PW-1:0]  wk_rem;
    logic [SW-1:0]  wk_start;
    logic [SW-1:0]  eff;
    logic           found;
    logic [IW-1:0]  idx;
    logic [IW-1:0]  fidx;

    cnt_ext = PW'(count);
    cm1     = cnt_ext - PW'(1);
    pe      = PW'(cmd.pos);
    case (cmd.sel)
      SEL_FIRST: pe = '0;
      SEL_LAST:  pe = (cmd.kind == K_INS) ? cnt_ext : cm1;
      default:   pe = PW'(cmd.pos);
    endcase

    // walk from the nearer end
    wpos = (state == S_CHECK) ? pe : pos_r;
    if (wpos > (cm1 >> 1)) begin
      wk_dir   = 1'b1;
      wk_start = tail;
      wk_rem   = cm1 - wpos;
    end else begin
      wk_dir   = 1'b0;
      wk_start = head;
      wk_rem   = wpos;
    end

    eff = fresh ? (dir ? prv_rd : nxt_rd) : cur;

    // lowest free slot within the current chunk of eight
    found = 1'b0;
    fidx  = '0;
    for (int j = 7; j >= 0; j--) begin
      idx = IW'(chunk) * IW'(8) + IW'(j);
      if ((int'(idx) < POOL_DEPTH) && !inuse[idx[SW-1:0]]) begin
        found = 1'b1;
        fidx  = idx;
      end
    end

    state_next = state;
    cmd_next   = cmd;
    word_next  = word;
    pos_r_next = pos_r;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    inuse_next = inuse;
    nslot_next = nslot;
    loc_next   = loc;
    cur_next   = cur;
    fresh_next = fresh;
    rem_next   = rem;
    dir_next   = dir;
    chunk_next = chunk;
    st_next    = st;
    dout_next  = dout;
    hword_next = hword;
    q_pop      = 1'b0;
    res_load   = 1'b0;

    w_we    = 1'b0;
    w_waddr = nslot;
    w_wdata = word;
    w_raddr = tail;
    n_we    = 1'b0;
    n_waddr = nslot;
    n_wdata = loc;
    p_we    = 1'b0;
    p_waddr = nslot;
    p_wdata = prv_rd;
    l_raddr = loc;

    case (state)
      S_IDLE: begin
        q_pop = 1'b1;
        if (q_valid) begin
          cmd_next   = q_cmd;
          word_next  = q_word;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        st_next    = ST_OK;
        dout_next  = '0;
        pos_r_next = pe;
        case (cmd.kind)
          K_CLR: begin
            inuse_next = '0;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            state_next = S_HEAD;
          end
          K_INS: begin
            if (pe > cnt_ext) begin
              st_next    = ST_RANGE;
              state_next = S_HEAD;
            end else if (count == CW'(POOL_DEPTH)) begin
              st_next    = ST_FULL;
              state_next = S_HEAD;
            end else begin
              chunk_next = '0;
              state_next = S_ALLOC;
            end
          end
          K_GET, K_SET, K_REM: begin
            if ((count == '0) || (pe >= cnt_ext)) begin
              st_next    = ST_RANGE;
              state_next = S_HEAD;
            end else begin
              dir_next   = wk_dir;
              cur_next   = wk_start;
              rem_next   = wk_rem;
              fresh_next = 1'b0;
              state_next = S_WALK;
            end
          end
          default: state_next = S_HEAD;
        endcase
      end
      S_ALLOC: begin
        if (found) begin
          nslot_next = fidx[SW-1:0];
          if ((count == '0) || (pos_r == cnt_ext)) begin
            state_next = S_APPEND;
          end else begin
            dir_next   = wk_dir;
            cur_next   = wk_start;
            rem_next   = wk_rem;
            fresh_next = 1'b0;
            state_next = S_WALK;
          end
        end else begin
          chunk_next = chunk + CHW'(1);
        end
      end
      S_APPEND: begin
        w_we = 1'b1;
        if (count == '0) begin
          head_next = nslot;
        end else begin
          n_we    = 1'b1;
          n_waddr = tail;
          n_wdata = nslot;
          p_we    = 1'b1;
          p_waddr = nslot;
          p_wdata = tail;
        end
        tail_next         = nslot;
        inuse_next[nslot] = 1'b1;
        count_next        = count + CW'(1);
        state_next        = S_HEAD;
      end
      S_WALK: begin
        l_raddr = eff;
        if (rem == '0) begin
          loc_next   = eff;
          state_next = S_ACT;
        end else begin
          cur_next   = eff;
          fresh_next = 1'b1;
          rem_next   = rem - PW'(1);
        end
      end
      S_ACT: begin
        w_raddr = loc;
        l_raddr = loc;
        case (cmd.kind)
          K_REM:   state_next = S_REMWR;
          K_INS:   state_next = S_LNK1;
          default: state_next = S_DCAP;
        endcase
      end
      S_DCAP: begin
        dout_next = word_rd;
        if (cmd.kind == K_SET) begin
          w_we    = 1'b1;
          w_waddr = loc;
        end
        state_next = S_HEAD;
      end
      S_REMWR: begin
        dout_next = word_rd;
        if (pos_r == '0) begin
          head_next = nxt_rd;
        end else begin
          n_we    = 1'b1;
          n_waddr = prv_rd;
          n_wdata = nxt_rd;
        end
        if (pos_r == cm1) begin
          tail_next = prv_rd;
        end else begin
          p_we    = 1'b1;
          p_waddr = nxt_rd;
          p_wdata = prv_rd;
        end
        inuse_next[loc] = 1'b0;
        count_next      = count - CW'(1);
        if (count == CW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end
        state_next = S_HEAD;
      end
      S_LNK1: begin
        w_we       = 1'b1;
        n_we       = 1'b1;
        p_we       = 1'b1;
        cur_next   = prv_rd;
        state_next = S_LNK2;
      end
      S_LNK2: begin
        p_we    = 1'b1;
        p_waddr = loc;
        p_wdata = nslot;
        if (pos_r == '0) begin
          head_next = nslot;
        end else begin
          n_we    = 1'b1;
          n_waddr = cur;
          n_wdata = nslot;
        end
        inuse_next[nslot] = 1'b1;
        count_next        = count + CW'(1);
        state_next        = S_HEAD;
      end
      S_HEAD: begin
        w_raddr    = head;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        hword_next = word_rd;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    logic [63:0] d_ext;
    logic [63:0] h_ext;
    logic [63:0] t_ext;
    d_ext           = 64'(dout);
    h_ext           = (count != '0) ? 64'(hword) : 64'd0;
    t_ext           = (count != '0) ? 64'(word_rd) : 64'd0;
    status_next     = st;
    data_out_next   = d_ext[31:0];
    item_count_next = 7'(count);
    head_data_next  = h_ext[31:0];
    tail_data_next  = t_ext[31:0];
    out_valid_next  = res_load ? 1'b1 : (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    word  <= word_next;
    pos_r <= pos_r_next;
    nslot <= nslot_next;
    loc   <= loc_next;
    cur   <= cur_next;
    fresh <= fresh_next;
    rem   <= rem_next;
    dir   <= dir_next;
    chunk <= chunk_next;
    st    <= st_next;
    dout  <= dout_next;
    hword <= hword_next;
    if (res_load) begin
      status     <= status_next;
      data_out   <= data_out_next;
      item_count <= item_count_next;
      head_data  <= head_data_next;
      tail_data  <= tail_data_next;
    end
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      inuse     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      inuse     <= inuse_next;
      out_valid <= out_valid_next;
    end
  end

  `ILE_ASSERT_ALWAYS(a_count_bound, count <= CW'(POOL_DEPTH), "entry count above pool depth")
  `ILE_ASSERT_ALWAYS(a_count_matches_pool, $countones(inuse) == count, "allocated slots != count")
  `ILE_ASSERT_IMPL(a_full_only_when_full, res_load && (st == ST_FULL), count == CW'(POOL_DEPTH), "full status with free slots")

endmodule

### sv/indexed_linked_list_engine_top.sv
// Indexed doubly linked list engine over a fixed node pool. Requests are
// taken into a two-entry queue and run one at a time by the list sequencer;
// each transaction yields one result held in an output register. Get, set
// and remove walk link by link to the position from the nearer end (at most
// half the count); pops follow no links. Inserts scan the pool for the lowest
// free slot in chunks of eight pool slots; an append or push back then links
// at the tail, while an insert inside the list also walks to its position.
// Clear, unknown codes and range or full errors skip the walk and relink.
// The sequencer waits in its output state while an earlier result is not
// yet taken.
module indexed_linked_list_engine_top import ile_pkg::*; #(
  parameter int POOL_DEPTH = 64,
  parameter int WORD_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          op,
  input  logic [POS_BITS-1:0] position,
  input  logic [31:0]         data_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [31:0]         data_out,
  output logic [6:0]          item_count,
  output logic [31:0]         head_data,
  output logic [31:0]         tail_data
);

  logic                 push;
  logic                 push_ready;
  cmd_t                 f_cmd;
  logic [WORD_BITS-1:0] f_word;
  logic                 q_valid;
  logic                 q_pop;
  cmd_t                 q_cmd;
  logic [WORD_BITS-1:0] q_word;

  ile_front #(.WORD_BITS(WORD_BITS)) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .position   (position),
    .data_in    (data_in),
    .push       (push),
    .push_ready (push_ready),
    .cmd        (f_cmd),
    .word       (f_word)
  );

  ile_queue #(.WORD_BITS(WORD_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (f_cmd),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd),
    .pop_word   (q_word)
  );

  ile_back #(.POOL_DEPTH(POOL_DEPTH), .WORD_BITS(WORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .q_word     (q_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_out   (data_out),
    .item_count (item_count),
    .head_data  (head_data),
    .tail_data  (tail_data)
  );

endmodule

### sim/indexed_linked_list_engine_checker.sv
// Result checker for the list engine: tracks accepted requests and compares results.
module indexed_linked_list_engine_checker import ile_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  op,
  input  logic [6:0]  position,
  input  logic [31:0] data_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [31:0] data_out,
  input  logic [6:0]  item_count,
  input  logic [31:0] head_data,
  input  logic [31:0] tail_data,
  output int          fail_count,
  output int          pending,
  output int          list_len
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SLOTS = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
    logic [6:0]  count;
    logic [31:0] head;
    logic [31:0] tail;
  } list_result_t;

  logic [31:0]  list_words[$];
  list_result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
  end

  function automatic logic [1:0] insert_word(int pos, logic [31:0] w);
    if (pos > list_words.size()) return ST_RANGE;
    if (list_words.size() == POOL_SLOTS) return ST_FULL;
    list_words.insert(pos, w);
    return ST_OK;
  endfunction

  function automatic list_result_t apply_request(logic [3:0] code, int pos,
                                                 logic [31:0] w);
    list_result_t r;
    int n;
    n = list_words.size();
    r = '0;
    r.status = ST_OK;
    case (code)
      OP_INSERT:     r.status = insert_word(pos, w);
      OP_PUSH_FRONT: r.status = insert_word(0, w);
      OP_PUSH_BACK:  r.status = insert_word(n, w);
      OP_GET: begin
        if (pos < n) r.word = list_words[pos];
        else r.status = ST_RANGE;
      end
      OP_SET: begin
        if (pos < n) begin
          r.word = list_words[pos];
          list_words[pos] = w;
        end else r.status = ST_RANGE;
      end
      OP_REMOVE: begin
        if (pos < n) begin
          r.word = list_words[pos];
          list_words.delete(pos);
        end else r.status = ST_RANGE;
      end
      OP_POP_FRONT: begin
        if (n > 0) r.word = list_words.pop_front();
        else r.status = ST_RANGE;
      end
      OP_POP_BACK: begin
        if (n > 0) r.word = list_words.pop_back();
        else r.status = ST_RANGE;
      end
      OP_CLEAR: list_words.delete();
      default: ;
    endcase
    r.count = 7'(list_words.size());
    if (list_words.size() > 0) begin
      r.head = list_words[0];
      r.tail = list_words[list_words.size()-1];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status);
            fail_count++;
          end
          if (data_out !== e.word) begin
            $error("data_out: expected %h actual %h", e.word, data_out);
            fail_count++;
          end
          if (item_count !== e.count) begin
            $error("item_count: expected %0d actual %0d", e.count, item_count);
            fail_count++;
          end
          if (head_data !== e.head) begin
            $error("head_data: expected %h actual %h", e.head, head_data);
            fail_count++;
          end
          if (tail_data !== e.tail) begin
            $error("tail_data: expected %h actual %h", e.tail, tail_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(op, int'(position), data_in));
      pending  = expected_results.size();
      list_len = list_words.size();
    end
  end

endmodule

### sim/indexed_linked_list_engine_top_test.sv
// Stimulus and verdict for the list engine regression.
module indexed_linked_list_engine_top_test;
  import ile_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1880;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  op = '0;
  logic [6:0]  position = '0;
  logic [31:0] data_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] data_out;
  logic [6:0]  item_count;
  logic [31:0] head_data;
  logic [31:0] tail_data;
  int          fail_count;
  int          pending;
  int          list_len;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  indexed_linked_list_engine_top DUT (.*);

  indexed_linked_list_engine_checker chk (.*);

  initial forever #1 clk = ~clk;

  // Transaction sender with random bursts and gaps.
  task automatic send(logic [3:0] code, int pos, logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    op       <= code;
    position <= 7'(pos);
    data_in  <= w;
    @(posedge clk iff in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  function automatic int pick_pos(int n);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 127);
      1:       return n;
      2:       return n > 0 ? n - 1 : 0;
      default: return $urandom_range(0, n);
    endcase
  endfunction

  // mode 0 grows the list, 1 shrinks it, 2 mixes everything
  task automatic random_item(int mode);
    int r, n;
    logic [3:0] code;
    n = list_len;
    r = $urandom_range(0, 99);
    if (r < 2) code = 4'($urandom_range(OP_CLEAR + 1, 15));
    else if (r < 3 && mode == 2) code = OP_CLEAR;
    else if (mode == 0) code = r < 70 ? 4'($urandom_range(OP_INSERT, OP_PUSH_BACK))
                                      : 4'($urandom_range(OP_GET, OP_POP_BACK));
    else if (mode == 1) code = r < 70 ? 4'($urandom_range(OP_REMOVE, OP_POP_BACK))
                                      : 4'($urandom_range(OP_INSERT, OP_SET));
    else code = 4'($urandom_range(OP_INSERT, OP_POP_BACK));
    send(code, pick_pos(n), $urandom());
  endtask

  // Receiver: one of three stall patterns at a time; long hold on request.
  initial begin
    int cyc, pattern;
    cyc = 0;
    pattern = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) pattern = $urandom_range(0, 2);
        case (pattern)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 3) != 0;
          default: out_ready <= $urandom_range(0, 3) == 0;
        endcase
      end
      cyc++;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int mode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list errors, extremes, every op
    send(OP_POP_FRONT, 0, 32'h0);
    send(OP_POP_BACK, 0, 32'h0);
    send(OP_REMOVE, 0, 32'h0);
    send(OP_GET, 0, 32'h0);
    send(OP_INSERT, 1, 32'h1234_5678);
    send(OP_PUSH_BACK, 0, 32'h0000_0000);
    send(OP_PUSH_FRONT, 0, 32'hFFFF_FFFF);
    send(OP_INSERT, 2, 32'hA5A5_A5A5);
    send(OP_INSERT, 1, 32'h5A5A_5A5A);
    send(OP_INSERT, 127, 32'h1);
    send(OP_GET, 0, 32'h0);
    send(OP_GET, 3, 32'h0);
    send(OP_GET, 4, 32'h0);
    send(OP_SET, 2, 32'hDEAD_BEEF);
    send(OP_SET, 64, 32'h0);
    send(OP_REMOVE, 1, 32'h0);
    send(OP_REMOVE, 127, 32'h0);
    send(OP_POP_FRONT, 0, 32'h0);
    send(OP_POP_BACK, 0, 32'h0);
    send(4'd9, 127, 32'hFFFF_FFFF);
    send(4'd15, 0, 32'h0);
    send(OP_CLEAR, 0, 32'h0);
    send(OP_GET, 0, 32'h0);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 120 == 0) begin
        mode = (i / 120) % 3;
        if ($urandom_range(0, 1) == 0) drain();
      end
      if (i == 600 || i == 1400) hold_req = 1'b1;
      random_item(mode);
    end

    in_valid <= 1'b0;
    // let the checker record the last transaction before polling
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
